// ----- design/rlbc_pkg.sv -----
package rlbc_pkg;

   // action codes
   localparam logic [2:0] ACT_SET_LEVEL = 3'd0;
   localparam logic [2:0] ACT_SET_COLOR = 3'd1;
   localparam logic [2:0] ACT_SET_MODE  = 3'd2;
   localparam logic [2:0] ACT_TICK      = 3'd3;
   localparam logic [2:0] ACT_TOGGLE    = 3'd4;

   // named color codes
   localparam logic [2:0] COLOR_BLUE    = 3'd0;
   localparam logic [2:0] COLOR_GREEN   = 3'd1;
   localparam logic [2:0] COLOR_RED     = 3'd2;
   localparam logic [2:0] COLOR_YELLOW  = 3'd3;
   localparam logic [2:0] COLOR_MAGENTA = 3'd4;
   localparam logic [2:0] COLOR_CYAN    = 3'd5;
   localparam logic [2:0] COLOR_WHITE   = 3'd6;
   localparam logic [2:0] COLOR_BLACK   = 3'd7;

   // mode codes
   localparam logic [2:0] MODE_NONE       = 3'd0;
   localparam logic [2:0] MODE_OFF        = 3'd1;
   localparam logic [2:0] MODE_ON         = 3'd2;
   localparam logic [2:0] MODE_BLINK_SLOW = 3'd3;
   localparam logic [2:0] MODE_BLINK_FAST = 3'd4;

   // channel slots
   localparam int unsigned NUM_CH = 3;
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   localparam logic [15:0] CMP_DARK  = 16'hFFFF;
   localparam logic [15:0] CMP_FULL  = 16'h0000;
   localparam logic [7:0]  LEVEL_MAX = 8'd100;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned REQ_USER_W = 3;
   localparam int unsigned RSP_DATA_W = 56;

   // one request after the input register
   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  color;
      logic [2:0]  mode;
      logic        level_zero;
      logic [15:0] level_cmp;
      logic        tick_slow;
      logic        tick_fast;
   } item_type;

   // 65535 - lvl*65535/100, with lvl*35/100 done by reciprocal (exact for lvl <= 100)
   function automatic logic [15:0] level_to_compare(input logic [6:0] lvl);
      logic [15:0] whole;
      logic [11:0] frac;
      logic [22:0] scaled;
      whole  = 16'(lvl) * 16'd655;
      frac   = 12'(lvl) * 12'd35;
      scaled = 23'(frac) * 23'd1311;
      return CMP_DARK - (whole + 16'(scaled[22:17]));
   endfunction

   // disable flags per named color, bit index is the channel slot
   function automatic logic [2:0] color_disable(input logic [2:0] color);
      logic [2:0] dis;
      dis = 3'b000;
      unique case (color)
         COLOR_BLUE:    dis = 3'b011;
         COLOR_GREEN:   dis = 3'b101;
         COLOR_RED:     dis = 3'b110;
         COLOR_YELLOW:  dis = 3'b100;
         COLOR_MAGENTA: dis = 3'b010;
         COLOR_CYAN:    dis = 3'b001;
         COLOR_WHITE:   dis = 3'b000;
         COLOR_BLACK:   dis = 3'b111;
         default:       dis = 3'b111;
      endcase
      return dis;
   endfunction

endpackage

// ----- design/rlbc_in_stage.sv -----
module rlbc_in_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // color_code[2:0], mode_code[5:3], level[13:6], tick_slow[14], tick_fast[15]
   input  logic [rlbc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[2:0]
   input  logic [rlbc_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              item_valid,
   input  logic                              item_ready,
   output rlbc_pkg::item_type                item
);

   logic               valid_ff;
   logic               valid_in;
   rlbc_pkg::item_type item_ff;
   rlbc_pkg::item_type item_in;
   logic [7:0]         level_raw;
   logic [6:0]         level_sat;
   logic               take;

   assign req_tready = !valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;
   assign level_raw  = req_tdata[13:6];

   always_comb begin
      if (level_raw > rlbc_pkg::LEVEL_MAX) begin
         level_sat = rlbc_pkg::LEVEL_MAX[6:0];
      end else begin
         level_sat = level_raw[6:0];
      end
      item_in.action     = req_tuser[2:0];
      item_in.color      = req_tdata[2:0];
      item_in.mode       = req_tdata[5:3];
      item_in.level_zero = (level_sat == 7'd0);
      item_in.level_cmp  = rlbc_pkg::level_to_compare(level_sat);
      item_in.tick_slow  = req_tdata[14];
      item_in.tick_fast  = req_tdata[15];
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- design/rlbc_core.sv -----
module rlbc_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   output logic                              item_ready,
   input  rlbc_pkg::item_type                item,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // red_compare[15:0], green_compare[31:16], blue_compare[47:32], lit[48],
   // color_now[51:49], mode_now[54:52], zero[55]
   output logic [rlbc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int unsigned NCH = rlbc_pkg::NUM_CH;

   // led state
   logic [NCH-1:0] dis_ff;
   logic [NCH-1:0] dis_in;
   logic [15:0]    level_cmp_ff [NCH];
   logic [15:0]    level_cmp_in [NCH];
   logic [15:0]    cmp_ff [NCH];
   logic [15:0]    cmp_in [NCH];
   logic [2:0]     color_ff;
   logic [2:0]     color_in;
   logic           lit_ff;
   logic           lit_in;
   logic [2:0]     mode_ff;
   logic [2:0]     mode_in;

   // result register
   logic                            out_valid_ff;
   logic [rlbc_pkg::RSP_DATA_W-1:0] out_data_ff;
   logic [rlbc_pkg::RSP_DATA_W-1:0] out_data_in;

   logic step;

   assign item_ready = !out_valid_ff || rsp_tready;
   assign step       = item_valid && item_ready;

   always_comb begin
      logic       turn_on;
      logic       turn_off;
      logic       full_on;
      logic [1:0] ch;
      turn_on  = 1'b0;
      turn_off = 1'b0;
      full_on  = 1'b0;
      ch       = rlbc_pkg::CH_BLUE;
      dis_in   = dis_ff;
      color_in = color_ff;
      lit_in   = lit_ff;
      mode_in  = mode_ff;
      for (int i = 0; i < NCH; i++) begin
         level_cmp_in[i] = level_cmp_ff[i];
         cmp_in[i]       = cmp_ff[i];
      end

      unique case (item.action)
         rlbc_pkg::ACT_SET_LEVEL: begin
            unique case (item.color)
               rlbc_pkg::COLOR_BLUE:  ch = rlbc_pkg::CH_BLUE;
               rlbc_pkg::COLOR_GREEN: ch = rlbc_pkg::CH_GREEN;
               rlbc_pkg::COLOR_RED:   ch = rlbc_pkg::CH_RED;
               default:               ch = rlbc_pkg::CH_BLUE;
            endcase
            // colors beyond the primaries leave every channel alone
            if (item.color == rlbc_pkg::COLOR_BLUE || item.color == rlbc_pkg::COLOR_GREEN
                || item.color == rlbc_pkg::COLOR_RED) begin
               dis_in[ch]       = item.level_zero;
               level_cmp_in[ch] = item.level_cmp;
               cmp_in[ch]       = item.level_cmp;
            end
         end
         rlbc_pkg::ACT_SET_COLOR: begin
            dis_in   = rlbc_pkg::color_disable(item.color);
            color_in = item.color;
            if (item.mode == rlbc_pkg::MODE_NONE) begin
               turn_on = lit_ff;
            end else if (item.mode <= rlbc_pkg::MODE_BLINK_FAST) begin
               mode_in = item.mode;
            end
         end
         rlbc_pkg::ACT_SET_MODE: begin
            if (item.mode <= rlbc_pkg::MODE_BLINK_FAST) begin
               mode_in  = item.mode;
               turn_off = (item.mode == rlbc_pkg::MODE_OFF);
               turn_on  = (item.mode == rlbc_pkg::MODE_ON);
            end
         end
         rlbc_pkg::ACT_TICK: begin
            priority if (mode_ff == rlbc_pkg::MODE_OFF) begin
               turn_off = 1'b1;
            end else if (mode_ff == rlbc_pkg::MODE_ON) begin
               turn_on = 1'b1;
            end else if ((mode_ff == rlbc_pkg::MODE_BLINK_SLOW && item.tick_slow)
                         || (mode_ff == rlbc_pkg::MODE_BLINK_FAST && item.tick_fast)) begin
               turn_off = lit_ff;
               turn_on  = !lit_ff;
            end else begin
               turn_on = 1'b0;
            end
         end
         rlbc_pkg::ACT_TOGGLE: begin
            turn_off = lit_ff;
            full_on  = !lit_ff;
         end
         default: begin
            turn_on = 1'b0;
         end
      endcase

      if (turn_on) begin
         lit_in = 1'b1;
         for (int i = 0; i < NCH; i++) begin
            cmp_in[i] = dis_in[i] ? rlbc_pkg::CMP_DARK : level_cmp_in[i];
         end
      end
      if (full_on) begin
         lit_in = 1'b1;
         for (int i = 0; i < NCH; i++) begin
            cmp_in[i] = dis_in[i] ? rlbc_pkg::CMP_DARK : rlbc_pkg::CMP_FULL;
         end
      end
      if (turn_off) begin
         lit_in = 1'b0;
         for (int i = 0; i < NCH; i++) begin
            cmp_in[i] = rlbc_pkg::CMP_DARK;
         end
      end

      out_data_in = {1'b0, mode_in, color_in, lit_in,
                     cmp_in[rlbc_pkg::CH_BLUE], cmp_in[rlbc_pkg::CH_GREEN],
                     cmp_in[rlbc_pkg::CH_RED]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dis_ff                         <= 3'b011;
         level_cmp_ff[rlbc_pkg::CH_RED]   <= rlbc_pkg::CMP_DARK;
         level_cmp_ff[rlbc_pkg::CH_GREEN] <= rlbc_pkg::CMP_DARK;
         level_cmp_ff[rlbc_pkg::CH_BLUE]  <= rlbc_pkg::CMP_FULL;
         for (int i = 0; i < NCH; i++) begin
            cmp_ff[i] <= rlbc_pkg::CMP_DARK;
         end
         color_ff     <= rlbc_pkg::COLOR_BLUE;
         lit_ff       <= 1'b0;
         mode_ff      <= rlbc_pkg::MODE_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            dis_ff   <= dis_in;
            color_ff <= color_in;
            lit_ff   <= lit_in;
            mode_ff  <= mode_in;
            for (int i = 0; i < NCH; i++) begin
               level_cmp_ff[i] <= level_cmp_in[i];
               cmp_ff[i]       <= cmp_in[i];
            end
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   // stored mode only ever takes a legal code
   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      mode_ff <= rlbc_pkg::MODE_BLINK_FAST)
      else $error("stored mode out of range");

   // state moves only with a request
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(lit_ff) && $stable(mode_ff) && $stable(color_ff))
      else $error("led state changed without a request");

   // a pending result always mirrors the current state
   a_result_tracks: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff[48] == lit_ff) && (out_data_ff[54:52] == mode_ff)
                       && (out_data_ff[15:0] == cmp_ff[rlbc_pkg::CH_RED]))
      else $error("result register out of step with state");

   // toggling a lit led leaves it dark
   a_toggle_off: assert property (@(posedge clock) disable iff (reset)
      step && item.action == rlbc_pkg::ACT_TOGGLE && lit_ff
      |=> !lit_ff && cmp_ff[rlbc_pkg::CH_RED] == rlbc_pkg::CMP_DARK
          && cmp_ff[rlbc_pkg::CH_BLUE] == rlbc_pkg::CMP_DARK)
      else $error("toggle did not turn the led off");
`endif

endmodule

// ----- design/rgb_led_blink_controller.sv -----
// rgb led blink controller: keeps the color, per-channel levels and blink mode of an
// rgb led and reports the three active-low pwm compare values (65535 = dark) after
// every request. each request carries one action (set level, set color, set mode,
// tick, toggle) in tuser and its operands in tdata, and yields exactly one response
// holding the compare values, the lit flag, the color and the stored mode. one
// request is taken per clock while the response port keeps up; a response passes through
// the input register, then the state update into the result register, and the rate
// is set by the state update loop. a stalled response port holds one finished
// response plus one request in the input register before req_tready drops.
module rgb_led_blink_controller (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // color_code[2:0], mode_code[5:3], level[13:6], tick_slow[14], tick_fast[15]
   input  logic [rlbc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[2:0]
   input  logic [rlbc_pkg::REQ_USER_W-1:0]   req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // red_compare[15:0], green_compare[31:16], blue_compare[47:32], lit[48],
   // color_now[51:49], mode_now[54:52], zero pad[55]
   output logic [rlbc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // request after the input register, with its level already saturated and converted
   logic               item_valid;
   logic               item_ready;
   rlbc_pkg::item_type item;

   // input register: level saturation and level-to-compare conversion
   rlbc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // led state update and result register
   rlbc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- sim/rgb_led_blink_controller_test.sv -----
`timescale 1ns / 1ps

module rgb_led_blink_controller_test;
   import rlbc_pkg::*;

   // codes past the defined ranges, the block must leave state alone for these
   localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI  = 3'd7;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   localparam int RANDOM_REQUESTS = 1950;
   localparam int MAX_IDLE        = 13;
   localparam int CALM_SPAN       = 40;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int REPORT_LIMIT    = 10;

   // status reported by one response
   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        lit;
      logic [2:0]  color;
      logic [2:0]  mode;
   } led_status_type;

   // one directed request, with a literal status where it is obvious
   typedef struct {
      logic [2:0]     act;
      logic [2:0]     color;
      logic [2:0]     mode;
      logic [7:0]     level;
      logic           tick_slow;
      logic           tick_fast;
      bit             pinned;
      led_status_type status;
   } plan_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   rgb_led_blink_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow of the led state, indexed by channel slot
   logic [2:0]  chan_off;
   logic [6:0]  chan_pct [NUM_CH];
   logic [15:0] chan_cmp [NUM_CH];
   logic        led_lit;
   logic [2:0]  shadow_color;
   logic [2:0]  shadow_mode;

   led_status_type status_due [$];
   plan_row_type   plan [$];
   int             fault_count;

   // active-low compare for a percentage, by integer division
   function automatic logic [15:0] pct_to_compare(input logic [6:0] pct);
      logic [31:0] prod;
      prod = 32'(pct) * 32'hFFFF;
      return CMP_DARK - 16'(prod / 100);
   endfunction

   // which channels a named color leaves dark
   function automatic logic [2:0] color_dark_mask(input logic [2:0] c);
      logic [2:0] mask;
      mask = '0;
      mask[CH_RED]   = (c == COLOR_BLUE) || (c == COLOR_GREEN) || (c == COLOR_CYAN) ||
                       (c == COLOR_BLACK);
      mask[CH_GREEN] = (c == COLOR_BLUE) || (c == COLOR_RED) || (c == COLOR_MAGENTA) ||
                       (c == COLOR_BLACK);
      mask[CH_BLUE]  = (c == COLOR_GREEN) || (c == COLOR_RED) || (c == COLOR_YELLOW) ||
                       (c == COLOR_BLACK);
      return mask;
   endfunction

   function automatic void light_up();
      led_lit = 1'b1;
      for (int ch = 0; ch < NUM_CH; ch++)
         chan_cmp[ch] = chan_off[ch] ? CMP_DARK : pct_to_compare(chan_pct[ch]);
   endfunction

   function automatic void go_dark();
      led_lit = 1'b0;
      for (int ch = 0; ch < NUM_CH; ch++)
         chan_cmp[ch] = CMP_DARK;
   endfunction

   function automatic void reset_shadow();
      chan_off = '0;
      chan_off[CH_RED]   = 1'b1;
      chan_off[CH_GREEN] = 1'b1;
      chan_pct[CH_RED]   = 7'd0;
      chan_pct[CH_GREEN] = 7'd0;
      chan_pct[CH_BLUE]  = 7'd100;
      for (int ch = 0; ch < NUM_CH; ch++)
         chan_cmp[ch] = CMP_DARK;
      led_lit      = 1'b0;
      shadow_color = COLOR_BLUE;
      shadow_mode  = MODE_NONE;
   endfunction

   // apply one request to the shadow and return the status it should report
   function automatic led_status_type next_led_status(input logic [2:0] act,
                                                      input logic [2:0] color,
                                                      input logic [2:0] mode,
                                                      input logic [7:0] level,
                                                      input logic tick_slow,
                                                      input logic tick_fast);
      logic [6:0]     pct;
      int             slot;
      led_status_type st;
      pct  = (level > LEVEL_MAX) ? 7'(LEVEL_MAX) : level[6:0];
      slot = -1;
      case (act)
         ACT_SET_LEVEL: begin
            // only the three primaries map to a channel
            if (color == COLOR_BLUE) slot = CH_BLUE;
            else if (color == COLOR_GREEN) slot = CH_GREEN;
            else if (color == COLOR_RED) slot = CH_RED;
            if (slot >= 0) begin
               chan_pct[slot] = pct;
               chan_off[slot] = (pct == 7'd0);
               chan_cmp[slot] = pct_to_compare(pct);
            end
         end
         ACT_SET_COLOR: begin
            chan_off     = color_dark_mask(color);
            shadow_color = color;
            if (mode == MODE_NONE) begin
               if (led_lit) light_up();
            end else if (mode <= MODE_BLINK_FAST) begin
               shadow_mode = mode;
            end
         end
         ACT_SET_MODE: begin
            if (mode <= MODE_BLINK_FAST) begin
               shadow_mode = mode;
               if (mode == MODE_OFF) go_dark();
               else if (mode == MODE_ON) light_up();
            end
         end
         ACT_TICK: begin
            if (shadow_mode == MODE_OFF) go_dark();
            else if (shadow_mode == MODE_ON) light_up();
            else if ((shadow_mode == MODE_BLINK_SLOW && tick_slow) ||
                     (shadow_mode == MODE_BLINK_FAST && tick_fast)) begin
               if (led_lit) go_dark();
               else light_up();
            end
         end
         ACT_TOGGLE: begin
            if (led_lit) begin
               go_dark();
            end else begin
               // full scale on every enabled channel, levels are ignored
               led_lit = 1'b1;
               for (int ch = 0; ch < NUM_CH; ch++)
                  chan_cmp[ch] = chan_off[ch] ? CMP_DARK : CMP_FULL;
            end
         end
         default: ;
      endcase
      st.red   = chan_cmp[CH_RED];
      st.green = chan_cmp[CH_GREEN];
      st.blue  = chan_cmp[CH_BLUE];
      st.lit   = led_lit;
      st.color = shadow_color;
      st.mode  = shadow_mode;
      return st;
   endfunction

   task automatic add_row(input logic [2:0] act, input logic [2:0] color,
                          input logic [2:0] mode, input logic [7:0] level,
                          input logic tick_slow, input logic tick_fast);
      plan_row_type r;
      r.act       = act;
      r.color     = color;
      r.mode      = mode;
      r.level     = level;
      r.tick_slow = tick_slow;
      r.tick_fast = tick_fast;
      r.pinned    = 1'b0;
      r.status    = '{default: '0};
      plan.push_back(r);
   endtask

   // row whose reported status is written out literally
   task automatic add_pinned(input logic [2:0] act, input logic [2:0] color,
                             input logic [2:0] mode, input logic [7:0] level,
                             input logic tick_slow, input logic tick_fast,
                             input logic [15:0] red, input logic [15:0] green,
                             input logic [15:0] blue, input logic lit,
                             input logic [2:0] color_now, input logic [2:0] mode_now);
      add_row(act, color, mode, level, tick_slow, tick_fast);
      plan[$].pinned = 1'b1;
      plan[$].status = '{red, green, blue, lit, color_now, mode_now};
   endtask

   // drive one request after an idle gap, queue its status once it is taken
   task automatic send_request(input plan_row_type r, input int gap);
      led_status_type st;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = r.act;
      req_tdata  = {r.tick_fast, r.tick_slow, r.level, r.mode, r.color};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      st = next_led_status(r.act, r.color, r.mode, r.level, r.tick_slow, r.tick_fast);
      if (r.pinned)
         status_due.push_back(r.status);
      else
         status_due.push_back(st);
      @(negedge clock);
   endtask

   // compare one response with the oldest queued status
   task automatic check_response(input logic [RSP_DATA_W-1:0] d);
      led_status_type got;
      led_status_type want;
      got.red   = d[15:0];
      got.green = d[31:16];
      got.blue  = d[47:32];
      got.lit   = d[48];
      got.color = d[51:49];
      got.mode  = d[54:52];
      if (status_due.size() == 0) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT)
            $display("unexpected response r=%h g=%h b=%h lit=%b color=%0d mode=%0d",
                     got.red, got.green, got.blue, got.lit, got.color, got.mode);
      end else begin
         want = status_due.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
             got.lit !== want.lit || got.color !== want.color || got.mode !== want.mode) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("mismatch expected r=%h g=%h b=%h lit=%b color=%0d mode=%0d",
                        want.red, want.green, want.blue, want.lit, want.color, want.mode);
               $display("         actual   r=%h g=%h b=%h lit=%b color=%0d mode=%0d",
                        got.red, got.green, got.blue, got.lit, got.color, got.mode);
            end
         end
      end
   endtask

   // random level: mostly in range, with the ends and saturating values
   function automatic logic [7:0] draw_level();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 8'd0;
      if (pick == 1) return LEVEL_MAX;
      if (pick <= 6) return 8'($urandom_range(1, 100));
      return 8'($urandom_range(101, 255));
   endfunction

   // random request: mostly defined actions and modes, a few spare codes
   function automatic plan_row_type draw_request();
      plan_row_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) r.act = ACT_SET_LEVEL;
      else if (pick < 45) r.act = ACT_SET_COLOR;
      else if (pick < 65) r.act = ACT_SET_MODE;
      else if (pick < 85) r.act = ACT_TICK;
      else if (pick < 95) r.act = ACT_TOGGLE;
      else r.act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      r.color = 3'($urandom_range(COLOR_BLUE, COLOR_BLACK));
      if ($urandom_range(0, 9) == 0)
         r.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      else
         r.mode = 3'($urandom_range(MODE_NONE, MODE_BLINK_FAST));
      r.level     = draw_level();
      r.tick_slow = 1'($urandom_range(0, 1));
      r.tick_fast = 1'($urandom_range(0, 1));
      r.pinned    = 1'b0;
      r.status    = '{default: '0};
      return r;
   endfunction

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #5_000_000;
      $display("rgb_led_blink_controller_test: errors");
      $finish;
   end

   // response side: random back-pressure per response, with calm stretches
   initial begin
      int stall;
      int span_left;
      bit calm;
      rsp_tready = 1'b0;
      span_left  = 0;
      calm       = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      @(negedge clock);
      forever begin
         if (span_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            span_left = CALM_SPAN;
         end
         span_left--;
         stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_response(rsp_tdata);
         @(negedge clock);
      end
   end

   // request side and end of run
   initial begin
      int gap;
      int span_left;
      int waited;
      bit calm;
      plan_row_type r;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      fault_count = 0;
      span_left   = 0;
      calm        = 1'b0;
      reset_shadow();

      // directed part: reset state, full scale, saturation, every action and mode
      add_pinned(ACT_TICK, COLOR_BLUE, MODE_NONE, 8'd0, 1'b1, 1'b1,
                 CMP_DARK, CMP_DARK, CMP_DARK, 1'b0, COLOR_BLUE, MODE_NONE);
      add_pinned(ACT_TOGGLE, COLOR_BLUE, MODE_NONE, 8'd0, 1'b0, 1'b0,
                 CMP_DARK, CMP_DARK, CMP_FULL, 1'b1, COLOR_BLUE, MODE_NONE);
      add_pinned(ACT_TOGGLE, COLOR_BLUE, MODE_NONE, 8'd0, 1'b0, 1'b0,
                 CMP_DARK, CMP_DARK, CMP_DARK, 1'b0, COLOR_BLUE, MODE_NONE);
      // level above 100 saturates, red goes to full scale at once even while dark
      add_pinned(ACT_SET_LEVEL, COLOR_RED, MODE_NONE, 8'd255, 1'b0, 1'b0,
                 CMP_FULL, CMP_DARK, CMP_DARK, 1'b0, COLOR_BLUE, MODE_NONE);
      // level zero disables the channel
      add_pinned(ACT_SET_LEVEL, COLOR_GREEN, MODE_NONE, 8'd0, 1'b0, 1'b0,
                 CMP_FULL, CMP_DARK, CMP_DARK, 1'b0, COLOR_BLUE, MODE_NONE);
      add_row(ACT_SET_LEVEL, COLOR_BLUE, MODE_NONE, 8'd1, 1'b0, 1'b0);
      // mixed color code on set level is a no-op
      add_row(ACT_SET_LEVEL, COLOR_MAGENTA, MODE_NONE, 8'd77, 1'b1, 1'b0);
      add_row(ACT_SET_COLOR, COLOR_WHITE, MODE_NONE, 8'd10, 1'b0, 1'b0);
      add_row(ACT_SET_MODE, COLOR_BLUE, MODE_ON, 8'd0, 1'b0, 1'b0);
      // color change while lit with no mode refreshes the outputs
      add_row(ACT_SET_COLOR, COLOR_RED, MODE_NONE, 8'd0, 1'b0, 1'b0);
      add_row(ACT_SET_COLOR, COLOR_YELLOW, MODE_BLINK_SLOW, 8'd0, 1'b0, 1'b0);
      add_row(ACT_TICK, COLOR_BLUE, MODE_NONE, 8'd0, 1'b1, 1'b0);
      add_row(ACT_TICK, COLOR_BLUE, MODE_NONE, 8'd0, 1'b0, 1'b1);
      add_row(ACT_SET_MODE, COLOR_BLUE, MODE_BLINK_FAST, 8'd0, 1'b0, 1'b0);
      add_row(ACT_TICK, COLOR_BLUE, MODE_NONE, 8'd0, 1'b0, 1'b1);
      add_row(ACT_TICK, COLOR_BLUE, MODE_NONE, 8'd0, 1'b1, 1'b1);
      // spare mode on set mode is ignored
      add_row(ACT_SET_MODE, COLOR_BLUE, MODE_SPARE_LO + 3'd1, 8'd0, 1'b0, 1'b0);
      // spare mode on set color keeps the stored mode, no refresh
      add_row(ACT_SET_COLOR, COLOR_CYAN, MODE_SPARE_HI, 8'd0, 1'b0, 1'b0);
      add_pinned(ACT_SET_MODE, COLOR_BLUE, MODE_OFF, 8'd0, 1'b0, 1'b0,
                 CMP_DARK, CMP_DARK, CMP_DARK, 1'b0, COLOR_CYAN, MODE_OFF);
      add_row(ACT_TICK, COLOR_BLUE, MODE_NONE, 8'd0, 1'b1, 1'b1);
      add_row(ACT_SET_LEVEL, COLOR_BLUE, MODE_NONE, 8'd50, 1'b0, 1'b0);
      add_row(ACT_SET_MODE, COLOR_BLUE, MODE_ON, 8'd0, 1'b0, 1'b0);
      add_row(ACT_SPARE_LO, COLOR_BLACK, MODE_OFF, 8'd0, 1'b0, 1'b0);
      add_row(ACT_SPARE_HI, COLOR_BLACK, MODE_SPARE_HI, 8'd255, 1'b1, 1'b1);
      add_row(ACT_SET_COLOR, COLOR_BLACK, MODE_NONE, 8'd0, 1'b0, 1'b0);
      add_row(ACT_TOGGLE, COLOR_BLUE, MODE_NONE, 8'd0, 1'b0, 1'b0);
      // toggle on with black: lit but every channel dark
      add_pinned(ACT_TOGGLE, COLOR_BLUE, MODE_NONE, 8'd0, 1'b0, 1'b0,
                 CMP_DARK, CMP_DARK, CMP_DARK, 1'b1, COLOR_BLACK, MODE_ON);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (span_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            span_left = CALM_SPAN;
         end
         span_left--;
         gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
         send_request(plan[i], gap);
      end

      // random part, checked against the shadow model
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (span_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            span_left = CALM_SPAN;
         end
         span_left--;
         gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
         r   = draw_request();
         send_request(r, gap);
      end
      req_tvalid = 1'b0;

      // drain, then wait for any stray response
      waited = 0;
      while (status_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      fault_count += status_due.size();

      if (fault_count == 0) begin
         $display("rgb_led_blink_controller_test: clean");
      end else begin
         $display("rgb_led_blink_controller_test: errors");
      end
      $finish;
   end

endmodule
